[design/dcas_pkg.sv]
package dcas_pkg;

  localparam logic OP_START = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  localparam logic [1:0] ST_REFUSED = 2'd0;
  localparam logic [1:0] ST_STARTED = 2'd1;
  localparam logic [1:0] ST_XFER    = 2'd2;
  localparam logic [1:0] ST_IDLE    = 2'd3;

  localparam logic [1:0] AMODE_INC        = 2'd0;
  localparam logic [1:0] AMODE_DEC        = 2'd1;
  localparam logic [1:0] AMODE_FIXED      = 2'd2;
  localparam logic [1:0] AMODE_INC_RELOAD = 2'd3;

  localparam logic [1:0] TIMING_IMMEDIATE = 2'd0;
  localparam logic [1:0] TIMING_VBLANK    = 2'd1;
  localparam logic [1:0] TIMING_HBLANK    = 2'd2;
  localparam logic [1:0] TIMING_SPECIAL   = 2'd3;

  localparam logic [7:0] REGION_IO        = 8'h04;
  localparam logic [7:0] REGION_WIDE_BASE = 8'h05;
  localparam logic [7:0] REGION_CART_LO   = 8'h08;
  localparam logic [7:0] REGION_CART_HI   = 8'h0D;

  localparam logic [31:0] MASK27 = 32'h07FF_FFFF;
  localparam logic [31:0] MASK28 = 32'h0FFF_FFFF;

  localparam logic [16:0] COUNT_DEFAULT  = 17'h04000;
  localparam logic [16:0] COUNT_LONG     = 17'h10000;
  localparam logic [1:0]  LONG_CHANNEL   = 2'd3;
  localparam logic [1:0]  FILL_CHANNEL   = 2'd0;

  typedef struct packed {
    logic [1:0]  status;
    logic [1:0]  channel;
    logic [27:0] read_addr;
    logic [27:0] write_addr;
    logic        is_word;
    logic        zero_fill;
    logic        last;
    logic        irq_raise;
    logic        dest_writeback;
    logic [27:0] writeback_addr;
    logic        disable_channel;
  } result_t;

  function automatic logic [31:0] mask_addr(input logic [31:0] a);
    return (a[31:24] < REGION_WIDE_BASE) ? (a & MASK27) : (a & MASK28);
  endfunction

  function automatic logic is_cart(input logic [7:0] region);
    return (region >= REGION_CART_LO) && (region <= REGION_CART_HI);
  endfunction

endpackage

[design/dma_channel_address_sequencer.sv]
// The result beat of an accepted input beat is registered in the result register.
// One item per cycle while the result register is empty or being taken (in_ready is low
// otherwise); the address step and count compare of the channel in flight finish in the
// accept cycle, so steps issue back to back. Reset (rst_n low, synchronous): no channel
// active, all counters and addresses zero, interrupt enable mask zero, output register empty.
module dma_channel_address_sequencer #(
  parameter int CHANNELS = 4
) (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        cfg_wr_en,
  input  logic [3:0]  cfg_wr_data,

  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_op,
  input  logic [1:0]  in_channel,
  input  logic [31:0] in_source_addr,
  input  logic [31:0] in_dest_addr,
  input  logic [15:0] in_word_count,
  input  logic [1:0]  in_dest_mode,
  input  logic [1:0]  in_src_mode,
  input  logic        in_word_size,
  input  logic        in_repeat_req,
  input  logic        in_irq_request,
  input  logic [1:0]  in_timing,
  input  logic [1:0]  in_blank_flags,

  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [1:0]  out_channel,
  output logic [27:0] out_read_addr,
  output logic [27:0] out_write_addr,
  output logic        out_is_word,
  output logic        out_zero_fill,
  output logic        out_last,
  output logic        out_irq_raise,
  output logic        out_dest_writeback,
  output logic [27:0] out_writeback_addr,
  output logic        out_disable_channel
);

  localparam logic [2:0] CH_LIMIT = 3'(CHANNELS);

  logic [3:0]  irq_mask_r;
  logic        active_r,    active_nxt;
  logic [1:0]  cur_ch_r,    cur_ch_nxt;
  logic [31:0] cur_src_r,   cur_src_nxt;
  logic [31:0] cur_dst_r,   cur_dst_nxt;
  logic [27:0] start_dst_r, start_dst_nxt;
  logic [16:0] remain_r,    remain_nxt;
  logic [1:0]  dmode_r,     dmode_nxt;
  logic [1:0]  smode_r,     smode_nxt;
  logic        word_r,      word_nxt;
  logic        rep_r,       rep_nxt;
  logic        irq_r,       irq_nxt;

  logic                  out_valid_r;
  dcas_pkg::result_t     res_r, res_nxt;

  logic        in_fire;
  logic [31:0] src_m, dst_m;
  logic [7:0]  sreg, dreg;
  logic        start_ok;
  logic [16:0] start_cnt;
  logic [31:0] size;
  logic [31:0] align;
  logic        zf;
  logic        is_last;

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  // Start checks.
  always_comb begin
    src_m     = dcas_pkg::mask_addr(in_source_addr);
    dst_m     = dcas_pkg::mask_addr(in_dest_addr);
    sreg      = src_m[31:24];
    dreg      = dst_m[31:24];
    start_ok  = 1'b1;
    if ({1'b0, in_channel} >= CH_LIMIT) start_ok = 1'b0;
    if (in_timing == dcas_pkg::TIMING_VBLANK && !in_blank_flags[0]) start_ok = 1'b0;
    if (in_timing == dcas_pkg::TIMING_HBLANK && !in_blank_flags[1]) start_ok = 1'b0;
    if ((in_channel == 2'd1 || in_channel == 2'd2) &&
        in_timing == dcas_pkg::TIMING_SPECIAL) start_ok = 1'b0;
    if (sreg == dcas_pkg::REGION_IO || dreg == dcas_pkg::REGION_IO) start_ok = 1'b0;
    if (dcas_pkg::is_cart(dreg)) start_ok = 1'b0;
    if (in_channel != dcas_pkg::LONG_CHANNEL &&
        (dcas_pkg::is_cart(sreg) || dreg > dcas_pkg::REGION_CART_HI)) start_ok = 1'b0;
    if (in_word_count == 16'd0) begin
      start_cnt = (in_channel == dcas_pkg::LONG_CHANNEL) ? dcas_pkg::COUNT_LONG
                                                         : dcas_pkg::COUNT_DEFAULT;
    end else begin
      start_cnt = {1'b0, in_word_count};
    end
  end

  // Transfer step terms.
  always_comb begin
    size    = word_r ? 32'd4 : 32'd2;
    align   = ~(size - 32'd1);
    zf      = (cur_ch_r == dcas_pkg::FILL_CHANNEL) && (cur_src_r[31:24] > dcas_pkg::REGION_CART_HI);
    is_last = remain_r <= 17'd1;
  end

  always_comb begin
    active_nxt    = active_r;
    cur_ch_nxt    = cur_ch_r;
    cur_src_nxt   = cur_src_r;
    cur_dst_nxt   = cur_dst_r;
    start_dst_nxt = start_dst_r;
    remain_nxt    = remain_r;
    dmode_nxt     = dmode_r;
    smode_nxt     = smode_r;
    word_nxt      = word_r;
    rep_nxt       = rep_r;
    irq_nxt       = irq_r;
    res_nxt       = '0;

    if (in_op == dcas_pkg::OP_START) begin
      res_nxt.channel = in_channel;
      if (start_ok) begin
        res_nxt.status = dcas_pkg::ST_STARTED;
        active_nxt     = 1'b1;
        cur_ch_nxt     = in_channel;
        cur_src_nxt    = src_m;
        cur_dst_nxt    = dst_m;
        start_dst_nxt  = dst_m[27:0];
        remain_nxt     = start_cnt;
        dmode_nxt      = in_dest_mode;
        smode_nxt      = in_src_mode;
        word_nxt       = in_word_size;
        rep_nxt        = in_repeat_req;
        irq_nxt        = in_irq_request;
      end else begin
        res_nxt.status = dcas_pkg::ST_REFUSED;
      end
    end else if (!active_r) begin
      res_nxt.status = dcas_pkg::ST_IDLE;
    end else begin
      res_nxt.status     = dcas_pkg::ST_XFER;
      res_nxt.channel    = cur_ch_r;
      res_nxt.read_addr  = zf ? 28'd0 : cur_src_r[27:0] & align[27:0];
      res_nxt.write_addr = cur_dst_r[27:0] & align[27:0];
      res_nxt.is_word    = word_r;
      res_nxt.zero_fill  = zf;
      res_nxt.last       = is_last;
      if (is_last) begin
        res_nxt.irq_raise       = irq_r && irq_mask_r[cur_ch_r];
        res_nxt.dest_writeback  = rep_r;
        res_nxt.writeback_addr  = rep_r ? start_dst_r : 28'd0;
        res_nxt.disable_channel = !rep_r;
      end

      unique case (dmode_r)
        dcas_pkg::AMODE_INC, dcas_pkg::AMODE_INC_RELOAD: cur_dst_nxt = cur_dst_r + size;
        dcas_pkg::AMODE_DEC:   cur_dst_nxt = cur_dst_r - size;
        dcas_pkg::AMODE_FIXED: cur_dst_nxt = cur_dst_r;
        default:               cur_dst_nxt = cur_dst_r;
      endcase
      // Source mode 3 behaves as fixed.
      unique case (smode_r)
        dcas_pkg::AMODE_INC: cur_src_nxt = cur_src_r + size;
        dcas_pkg::AMODE_DEC: cur_src_nxt = cur_src_r - size;
        default:             cur_src_nxt = cur_src_r;
      endcase

      if (is_last) begin
        remain_nxt = 17'd0;
        active_nxt = 1'b0;
      end else begin
        remain_nxt = remain_r - 17'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      irq_mask_r  <= '0;
      active_r    <= 1'b0;
      cur_ch_r    <= '0;
      cur_src_r   <= '0;
      cur_dst_r   <= '0;
      start_dst_r <= '0;
      remain_r    <= '0;
      dmode_r     <= '0;
      smode_r     <= '0;
      word_r      <= 1'b0;
      rep_r       <= 1'b0;
      irq_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        irq_mask_r <= cfg_wr_data;
      end
      if (in_fire) begin
        active_r    <= active_nxt;
        cur_ch_r    <= cur_ch_nxt;
        cur_src_r   <= cur_src_nxt;
        cur_dst_r   <= cur_dst_nxt;
        start_dst_r <= start_dst_nxt;
        remain_r    <= remain_nxt;
        dmode_r     <= dmode_nxt;
        smode_r     <= smode_nxt;
        word_r      <= word_nxt;
        rep_r       <= rep_nxt;
        irq_r       <= irq_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // The result register holds payload only; its valid bit is reset above.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_status          = res_r.status;
  assign out_channel         = res_r.channel;
  assign out_read_addr       = res_r.read_addr;
  assign out_write_addr      = res_r.write_addr;
  assign out_is_word         = res_r.is_word;
  assign out_zero_fill       = res_r.zero_fill;
  assign out_last            = res_r.last;
  assign out_irq_raise       = res_r.irq_raise;
  assign out_dest_writeback  = res_r.dest_writeback;
  assign out_writeback_addr  = res_r.writeback_addr;
  assign out_disable_channel = res_r.disable_channel;

  a_idle_count_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !active_r |-> remain_r == 17'd0)
    else $error("idle sequencer holds a nonzero count");

  a_last_one_action: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.last) |-> (res_r.dest_writeback != res_r.disable_channel))
    else $error("last beat must either write back or disable");

  a_fill_no_read: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.zero_fill) |-> res_r.read_addr == 28'd0)
    else $error("zero fill beat carries a read address");

  a_last_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_op == dcas_pkg::OP_STEP && active_r && is_last) |=> !active_r)
    else $error("sequencer stayed active after its last transfer");

  a_start_fields_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (res_r.status == dcas_pkg::ST_REFUSED ||
                     res_r.status == dcas_pkg::ST_STARTED))
      |-> (res_r.read_addr == 28'd0 && res_r.write_addr == 28'd0 && !res_r.last))
    else $error("start result carries transfer fields");

endmodule

[tb/sv/dcas_checker.sv]
module dcas_checker #(
  parameter int CHANNELS = 4
) (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        cfg_wr_en,
  input  logic [3:0]  cfg_wr_data,

  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        in_op,
  input  logic [1:0]  in_channel,
  input  logic [31:0] in_source_addr,
  input  logic [31:0] in_dest_addr,
  input  logic [15:0] in_word_count,
  input  logic [1:0]  in_dest_mode,
  input  logic [1:0]  in_src_mode,
  input  logic        in_word_size,
  input  logic        in_repeat_req,
  input  logic        in_irq_request,
  input  logic [1:0]  in_timing,
  input  logic [1:0]  in_blank_flags,

  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [1:0]  out_status,
  input  logic [1:0]  out_channel,
  input  logic [27:0] out_read_addr,
  input  logic [27:0] out_write_addr,
  input  logic        out_is_word,
  input  logic        out_zero_fill,
  input  logic        out_last,
  input  logic        out_irq_raise,
  input  logic        out_dest_writeback,
  input  logic [27:0] out_writeback_addr,
  input  logic        out_disable_channel,

  output int          mismatch_count,
  output int          results_owed
);

  logic [3:0]  irq_en;
  logic        busy;
  logic [1:0]  run_ch;
  logic [31:0] run_src;
  logic [31:0] run_dst;
  logic [27:0] home_dst;
  logic [16:0] beats_left;
  logic [1:0]  run_dmode;
  logic [1:0]  run_smode;
  logic        run_word;
  logic        run_rep;
  logic        run_irq;
  dcas_pkg::result_t owed_q[$];

  // Low regions keep 27 address bits, everything from the wide base up keeps 28.
  function automatic logic [31:0] fold_addr(input logic [31:0] a);
    if (a[31:24] >= dcas_pkg::REGION_WIDE_BASE) return {4'h0, a[27:0]};
    return {5'h0, a[26:0]};
  endfunction

  task automatic sequence_beat(output dcas_pkg::result_t r);
    logic [31:0] src_f;
    logic [31:0] dst_f;
    logic [31:0] step;
    logic [31:0] keep;
    logic [7:0]  sreg;
    logic [7:0]  dreg;
    logic [16:0] count;
    logic        refuse;
    logic        fill;
    logic        final_beat;
    r = '0;
    if (in_op == dcas_pkg::OP_START) begin
      src_f = fold_addr(in_source_addr);
      dst_f = fold_addr(in_dest_addr);
      sreg = src_f[31:24];
      dreg = dst_f[31:24];
      r.channel = in_channel;
      refuse = (int'(in_channel) >= CHANNELS)
            || (in_timing == dcas_pkg::TIMING_VBLANK && !in_blank_flags[0])
            || (in_timing == dcas_pkg::TIMING_HBLANK && !in_blank_flags[1])
            || (in_timing == dcas_pkg::TIMING_SPECIAL &&
                (in_channel == 2'd1 || in_channel == 2'd2))
            || sreg == dcas_pkg::REGION_IO || dreg == dcas_pkg::REGION_IO
            || (dreg >= dcas_pkg::REGION_CART_LO && dreg <= dcas_pkg::REGION_CART_HI)
            || (in_channel != dcas_pkg::LONG_CHANNEL &&
                ((sreg >= dcas_pkg::REGION_CART_LO && sreg <= dcas_pkg::REGION_CART_HI) ||
                 dreg > dcas_pkg::REGION_CART_HI));
      if (refuse) begin
        r.status = dcas_pkg::ST_REFUSED;
      end else begin
        if (in_word_count != 16'd0) count = {1'b0, in_word_count};
        else if (in_channel == dcas_pkg::LONG_CHANNEL) count = dcas_pkg::COUNT_LONG;
        else count = dcas_pkg::COUNT_DEFAULT;
        busy = 1'b1;
        run_ch = in_channel;
        run_src = src_f;
        run_dst = dst_f;
        home_dst = dst_f[27:0];
        beats_left = count;
        run_dmode = in_dest_mode;
        run_smode = in_src_mode;
        run_word = in_word_size;
        run_rep = in_repeat_req;
        run_irq = in_irq_request;
        r.status = dcas_pkg::ST_STARTED;
      end
    end else if (!busy) begin
      r.status = dcas_pkg::ST_IDLE;
    end else begin
      step = run_word ? 32'd4 : 32'd2;
      keep = ~(step - 32'd1);
      // Channel 0 writes zeros while its source sits above the cartridge area.
      fill = (run_ch == dcas_pkg::FILL_CHANNEL) && (run_src[31:24] > dcas_pkg::REGION_CART_HI);
      final_beat = (beats_left <= 17'd1);
      r.status = dcas_pkg::ST_XFER;
      r.channel = run_ch;
      r.read_addr = fill ? 28'd0 : (run_src[27:0] & keep[27:0]);
      r.write_addr = run_dst[27:0] & keep[27:0];
      r.is_word = run_word;
      r.zero_fill = fill;
      r.last = final_beat;
      if (final_beat) begin
        r.irq_raise = run_irq & irq_en[run_ch];
        r.dest_writeback = run_rep;
        r.writeback_addr = run_rep ? home_dst : 28'd0;
        r.disable_channel = !run_rep;
        busy = 1'b0;
        beats_left = '0;
      end else begin
        beats_left = beats_left - 17'd1;
      end
      case (run_dmode)
        dcas_pkg::AMODE_INC, dcas_pkg::AMODE_INC_RELOAD: run_dst = run_dst + step;
        dcas_pkg::AMODE_DEC: run_dst = run_dst - step;
        default: ;
      endcase
      case (run_smode)
        dcas_pkg::AMODE_INC: run_src = run_src + step;
        dcas_pkg::AMODE_DEC: run_src = run_src - step;
        default: ;
      endcase
    end
  endtask

  task automatic check_field(input string name, input logic [27:0] want_v, got_v);
    if (want_v !== got_v) begin
      $display("%0t: %s expected 0x%0h got 0x%0h", $time, name, want_v, got_v);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    dcas_pkg::result_t seen;
    dcas_pkg::result_t want;
    dcas_pkg::result_t fresh;
    if (!rst_n) begin
      irq_en = '0;
      busy = 1'b0;
      run_ch = '0;
      run_src = '0;
      run_dst = '0;
      home_dst = '0;
      beats_left = '0;
      run_dmode = '0;
      run_smode = '0;
      run_word = 1'b0;
      run_rep = 1'b0;
      run_irq = 1'b0;
      mismatch_count = 0;
      owed_q.delete();
      results_owed <= 0;
    end else begin
      // The result beat at this edge always belongs to an earlier input beat.
      if (out_valid && out_ready) begin
        seen.status = out_status;
        seen.channel = out_channel;
        seen.read_addr = out_read_addr;
        seen.write_addr = out_write_addr;
        seen.is_word = out_is_word;
        seen.zero_fill = out_zero_fill;
        seen.last = out_last;
        seen.irq_raise = out_irq_raise;
        seen.dest_writeback = out_dest_writeback;
        seen.writeback_addr = out_writeback_addr;
        seen.disable_channel = out_disable_channel;
        if (owed_q.size() == 0) begin
          $display("%0t: result beat with nothing expected, status 0x%0h", $time, out_status);
          mismatch_count++;
        end else begin
          want = owed_q.pop_front();
          check_field("status", 28'(want.status), 28'(seen.status));
          check_field("channel", 28'(want.channel), 28'(seen.channel));
          check_field("read_addr", want.read_addr, seen.read_addr);
          check_field("write_addr", want.write_addr, seen.write_addr);
          check_field("is_word", 28'(want.is_word), 28'(seen.is_word));
          check_field("zero_fill", 28'(want.zero_fill), 28'(seen.zero_fill));
          check_field("last", 28'(want.last), 28'(seen.last));
          check_field("irq_raise", 28'(want.irq_raise), 28'(seen.irq_raise));
          check_field("dest_writeback", 28'(want.dest_writeback),
                      28'(seen.dest_writeback));
          check_field("writeback_addr", want.writeback_addr, seen.writeback_addr);
          check_field("disable_channel", 28'(want.disable_channel),
                      28'(seen.disable_channel));
        end
      end
      // A beat accepted at this edge still sees the mask from before the write.
      if (in_valid && in_ready) begin
        sequence_beat(fresh);
        owed_q.push_back(fresh);
      end
      if (cfg_wr_en) irq_en = cfg_wr_data;
      results_owed <= owed_q.size();
    end
  end

endmodule

[tb/sv/tb.sv]
module tb;

  typedef struct {
    logic        op;
    logic [1:0]  channel;
    logic [31:0] src;
    logic [31:0] dst;
    logic [15:0] count;
    logic [1:0]  dmode;
    logic [1:0]  smode;
    logic        word;
    logic        rep;
    logic        irq;
    logic [1:0]  timing;
    logic [1:0]  flags;
  } dma_req_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [3:0]  cfg_wr_data;
  logic        in_valid;
  logic        in_ready;
  logic        in_op;
  logic [1:0]  in_channel;
  logic [31:0] in_source_addr;
  logic [31:0] in_dest_addr;
  logic [15:0] in_word_count;
  logic [1:0]  in_dest_mode;
  logic [1:0]  in_src_mode;
  logic        in_word_size;
  logic        in_repeat_req;
  logic        in_irq_request;
  logic [1:0]  in_timing;
  logic [1:0]  in_blank_flags;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  out_status;
  logic [1:0]  out_channel;
  logic [27:0] out_read_addr;
  logic [27:0] out_write_addr;
  logic        out_is_word;
  logic        out_zero_fill;
  logic        out_last;
  logic        out_irq_raise;
  logic        out_dest_writeback;
  logic [27:0] out_writeback_addr;
  logic        out_disable_channel;

  int mismatch_count;
  int results_owed;
  int send_idle_pct;
  int recv_idle_pct;
  int beats_sent;
  bit hold_req;

  dma_channel_address_sequencer #(.CHANNELS(4)) DUT (.*);

  dcas_checker #(.CHANNELS(4)) CHK (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end

  // Receiver: random backpressure, plus one long hold-off per phase on request.
  initial begin
    int hold_cycles;
    hold_cycles = 0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_cycles = 250;
      end
      if (hold_cycles > 0) begin
        out_ready <= 1'b0;
        hold_cycles--;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  function automatic dma_req_t any_req();
    dma_req_t r;
    r.op = 1'($urandom_range(0, 1));
    r.channel = 2'($urandom_range(0, 3));
    r.src = $urandom;
    r.dst = $urandom;
    r.count = 16'($urandom);
    r.dmode = 2'($urandom_range(0, 3));
    r.smode = 2'($urandom_range(0, 3));
    r.word = 1'($urandom_range(0, 1));
    r.rep = 1'($urandom_range(0, 1));
    r.irq = 1'($urandom_range(0, 1));
    r.timing = 2'($urandom_range(0, 3));
    r.flags = 2'($urandom_range(0, 3));
    return r;
  endfunction

  function automatic dma_req_t step_req();
    dma_req_t r;
    r = any_req();
    r.op = dcas_pkg::OP_STEP;
    return r;
  endfunction

  function automatic dma_req_t start_req(input logic [1:0] ch, input logic [31:0] src, dst,
                                         input logic [15:0] cnt, input logic [1:0] dm, sm,
                                         input logic w, rep, irq, input logic [1:0] tim, fl);
    dma_req_t r;
    r.op = dcas_pkg::OP_START;
    r.channel = ch;
    r.src = src;
    r.dst = dst;
    r.count = cnt;
    r.dmode = dm;
    r.smode = sm;
    r.word = w;
    r.rep = rep;
    r.irq = irq;
    r.timing = tim;
    r.flags = fl;
    return r;
  endfunction

  // Random address whose region the block takes for this channel and direction.
  function automatic logic [31:0] legal_addr(input bit for_src, input logic [1:0] ch);
    logic [31:0] a;
    logic [7:0]  raw;
    logic [7:0]  m;
    bit          ok;
    a = $urandom;
    if ($urandom_range(0, 3) == 0) a[23:4] = a[0] ? 20'hFFFFF : 20'h00000;
    do begin
      raw = 8'($urandom_range(0, 255));
      m = (raw < dcas_pkg::REGION_WIDE_BASE) ? raw : {4'h0, raw[3:0]};
      if (for_src)
        ok = m != dcas_pkg::REGION_IO &&
             (ch == dcas_pkg::LONG_CHANNEL ||
              m < dcas_pkg::REGION_CART_LO || m > dcas_pkg::REGION_CART_HI);
      else
        ok = m != dcas_pkg::REGION_IO &&
             (m < dcas_pkg::REGION_CART_LO ||
              (ch == dcas_pkg::LONG_CHANNEL && m > dcas_pkg::REGION_CART_HI));
    end while (!ok);
    a[31:24] = raw;
    return a;
  endfunction

  function automatic dma_req_t legal_start();
    dma_req_t r;
    int pick;
    r = any_req();
    r.op = dcas_pkg::OP_START;
    r.src = legal_addr(1'b1, r.channel);
    r.dst = legal_addr(1'b0, r.channel);
    if (r.timing == dcas_pkg::TIMING_SPECIAL && (r.channel == 2'd1 || r.channel == 2'd2))
      r.timing = 2'($urandom_range(0, 2));
    if (r.timing == dcas_pkg::TIMING_VBLANK) r.flags[0] = 1'b1;
    if (r.timing == dcas_pkg::TIMING_HBLANK) r.flags[1] = 1'b1;
    r.irq = ($urandom_range(0, 9) < 7);
    pick = $urandom_range(0, 99);
    if (pick < 70) r.count = 16'($urandom_range(1, 6));
    else if (pick < 90) r.count = 16'($urandom_range(7, 40));
    else if (pick < 95) r.count = 16'($urandom);
    else r.count = 16'd0;
    return r;
  endfunction

  task automatic offer(input dma_req_t q);
    int gap;
    gap = 0;
    while (gap < 12 && $urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op <= q.op;
    in_channel <= q.channel;
    in_source_addr <= q.src;
    in_dest_addr <= q.dst;
    in_word_count <= q.count;
    in_dest_mode <= q.dmode;
    in_src_mode <= q.smode;
    in_word_size <= q.word;
    in_repeat_req <= q.rep;
    in_irq_request <= q.irq;
    in_timing <= q.timing;
    in_blank_flags <= q.flags;
    do @(posedge clk); while (!in_ready);
    beats_sent++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (results_owed != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_mask(input logic [3:0] v);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Mostly legal starts followed by enough steps to finish (sometimes a few idle
  // steps, sometimes cut short by the next start), mixed with random noise.
  task automatic run_random(input int upto, input int s_idle, input int r_idle);
    dma_req_t q;
    int       k;
    bit       pressed;
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    pressed = 1'b0;
    while (beats_sent < upto) begin
      if (!pressed && beats_sent > upto - 300) begin
        hold_req = 1'b1;
        pressed = 1'b1;
      end
      if ($urandom_range(0, 3) != 0) begin
        q = legal_start();
        offer(q);
        if (q.count != 16'd0 && q.count <= 16'd40) begin
          if ($urandom_range(0, 9) == 0) k = int'($urandom_range(1, q.count));
          else k = int'(q.count) + int'($urandom_range(0, 2));
        end else begin
          k = int'($urandom_range(1, 10));
        end
        repeat (k) offer(step_req());
      end else if ($urandom_range(0, 1) == 0) begin
        q = any_req();
        q.op = dcas_pkg::OP_START;
        offer(q);
      end else begin
        offer(step_req());
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_valid = 1'b0;
    in_op = dcas_pkg::OP_START;
    in_channel = '0;
    in_source_addr = '0;
    in_dest_addr = '0;
    in_word_count = '0;
    in_dest_mode = '0;
    in_src_mode = '0;
    in_word_size = 1'b0;
    in_repeat_req = 1'b0;
    in_irq_request = 1'b0;
    in_timing = '0;
    in_blank_flags = '0;
    send_idle_pct = 24;
    recv_idle_pct = 70;
    beats_sent = 0;
    hold_req = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_mask(4'hF);

    // Step with nothing in flight, then a short run whose source wraps below zero.
    offer(step_req());
    offer(start_req(2'd0, 32'h0000_0000, 32'h0200_0000, 16'd2,
                    dcas_pkg::AMODE_INC, dcas_pkg::AMODE_DEC,
                    1'b0, 1'b0, 1'b1, dcas_pkg::TIMING_IMMEDIATE, 2'b00));
    repeat (3) offer(step_req());
    // Long default count on channel 3, cartridge source and high destination.
    offer(start_req(2'd3, 32'h0800_0001, 32'h0E00_0003, 16'd0,
                    dcas_pkg::AMODE_DEC, dcas_pkg::AMODE_FIXED,
                    1'b1, 1'b1, 1'b0, dcas_pkg::TIMING_SPECIAL, 2'b00));
    offer(step_req());
    offer(start_req(2'd1, 32'h0200_0000, 32'h0300_0000, 16'd4,
                    dcas_pkg::AMODE_INC, dcas_pkg::AMODE_INC,
                    1'b1, 1'b0, 1'b1, dcas_pkg::TIMING_SPECIAL, 2'b11));
    offer(step_req());
    // A new start replaces the one in flight; channel 0 from the top region zero-fills.
    offer(start_req(2'd0, 32'hFFFF_FFFF, 32'h03FF_FFFF, 16'd0,
                    dcas_pkg::AMODE_FIXED, dcas_pkg::AMODE_INC_RELOAD,
                    1'b0, 1'b1, 1'b1, dcas_pkg::TIMING_VBLANK, 2'b01));
    offer(step_req());
    offer(start_req(2'd2, 32'h0200_0000, 32'h0300_0000, 16'd1,
                    dcas_pkg::AMODE_INC, dcas_pkg::AMODE_INC,
                    1'b0, 1'b0, 1'b0, dcas_pkg::TIMING_VBLANK, 2'b10));
    offer(start_req(2'd2, 32'h0200_0000, 32'h0300_0000, 16'd1,
                    dcas_pkg::AMODE_INC, dcas_pkg::AMODE_INC,
                    1'b0, 1'b0, 1'b0, dcas_pkg::TIMING_HBLANK, 2'b01));
    offer(start_req(2'd2, 32'h0400_0000, 32'h0300_0000, 16'd1,
                    dcas_pkg::AMODE_INC, dcas_pkg::AMODE_INC,
                    1'b0, 1'b0, 1'b0, dcas_pkg::TIMING_HBLANK, 2'b11));
    offer(start_req(2'd2, 32'h0200_0000, 32'h0400_1234, 16'd1,
                    dcas_pkg::AMODE_INC, dcas_pkg::AMODE_INC,
                    1'b0, 1'b0, 1'b0, dcas_pkg::TIMING_IMMEDIATE, 2'b00));
    offer(start_req(2'd0, 32'h0200_0000, 32'h0D00_0000, 16'd1,
                    dcas_pkg::AMODE_INC, dcas_pkg::AMODE_INC,
                    1'b0, 1'b0, 1'b0, dcas_pkg::TIMING_IMMEDIATE, 2'b00));
    offer(start_req(2'd1, 32'h0900_0000, 32'h0300_0000, 16'd1,
                    dcas_pkg::AMODE_INC, dcas_pkg::AMODE_INC,
                    1'b0, 1'b0, 1'b0, dcas_pkg::TIMING_IMMEDIATE, 2'b00));
    offer(start_req(2'd2, 32'h0200_0000, 32'h0E00_0000, 16'd1,
                    dcas_pkg::AMODE_INC, dcas_pkg::AMODE_INC,
                    1'b0, 1'b0, 1'b0, dcas_pkg::TIMING_IMMEDIATE, 2'b00));
    // A wide-region source that folds down onto the IO region.
    offer(start_req(2'd3, 32'h1400_0000, 32'h0300_0000, 16'd1,
                    dcas_pkg::AMODE_INC, dcas_pkg::AMODE_INC,
                    1'b0, 1'b0, 1'b0, dcas_pkg::TIMING_IMMEDIATE, 2'b00));
    // Single-beat repeat run: interrupt raised and destination written back.
    offer(start_req(2'd2, 32'h0500_0000, 32'h07FF_FFFE, 16'd1,
                    dcas_pkg::AMODE_INC_RELOAD, dcas_pkg::AMODE_DEC,
                    1'b0, 1'b1, 1'b1, dcas_pkg::TIMING_HBLANK, 2'b10));
    offer(step_req());
    offer(start_req(2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF,
                    dcas_pkg::AMODE_INC_RELOAD, dcas_pkg::AMODE_INC_RELOAD,
                    1'b1, 1'b1, 1'b1, dcas_pkg::TIMING_SPECIAL, 2'b11));
    repeat (2) offer(step_req());

    settle();
    write_mask(4'h0);
    run_random(520, 24, 70);
    settle();
    write_mask(4'($urandom_range(1, 14)));
    run_random(1020, 70, 24);
    settle();
    write_mask(4'hF);
    run_random(1520, 0, 0);
    settle();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && results_owed == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
